FILE: rtl/pkn_pkg.sv
// Shared types, constants and datapath operation codes for the normalized
// polynomial kernel. No dependencies; the datapath, controller and top level import this package.
package pkn_pkg;

    // Fixed-point formats.
    localparam int ELEM_FRAC_BITS = 12;
    localparam int OUT_FRAC_BITS  = 16;
    localparam int ACC_W          = 48;
    localparam int XMAG_W         = 50;
    localparam int MUL_W          = 48;

    // Unnormalized path: x is moved to Q32, and saturates at 2^15.
    localparam int UN_SHIFT = 32 - 2 * ELEM_FRAC_BITS;
    localparam int UN_LIMIT = 15 + 2 * ELEM_FRAC_BITS;
    localparam logic [XMAG_W-1:0] C_ONE = XMAG_W'(1) << (2 * ELEM_FRAC_BITS);

    // Configuration register indexes.
    localparam logic [1:0] REG_DEGREE    = 2'd0;
    localparam logic [1:0] REG_ADD_ONE   = 2'd1;
    localparam logic [1:0] REG_NORMALIZE = 2'd2;

    // Datapath operations.
    localparam logic [3:0] OP_NONE      = 4'd0;
    localparam logic [3:0] OP_ACC       = 4'd1;
    localparam logic [3:0] OP_PREP      = 4'd2;
    localparam logic [3:0] OP_SCALE     = 4'd3;
    localparam logic [3:0] OP_ROOT_INIT = 4'd4;
    localparam logic [3:0] OP_ROOT_STEP = 4'd5;
    localparam logic [3:0] OP_LOAD_SB   = 4'd6;
    localparam logic [3:0] OP_MUL_MM    = 4'd7;
    localparam logic [3:0] OP_MUL_STEP  = 4'd8;
    localparam logic [3:0] OP_DIV_INIT  = 4'd9;
    localparam logic [3:0] OP_DIV_STEP  = 4'd10;
    localparam logic [3:0] OP_CLAMP     = 4'd11;
    localparam logic [3:0] OP_MUL_POW   = 4'd12;
    localparam logic [3:0] OP_POW_UPD   = 4'd13;
    localparam logic [3:0] OP_OUT       = 4'd14;

    typedef struct packed {
        logic [3:0] degree;
        logic       add_one;
        logic       normalize;
    } t_cfg;

    typedef struct packed {
        logic [3:0] op;
    } t_dp_cmd;

    typedef struct packed {
        logic       special;   // a self-kernel sum is zero under normalization
        logic       clip;      // result must saturate
        logic       s_small;   // root operand still below 2^60
        logic       q_top;     // quotient reached 2^31
        logic [7:0] total;     // division step count
    } t_dp_stat;

endpackage

FILE: rtl/pkn_in_if.sv
// Input channel: one element pair per transfer.
// Depends on nothing.
interface pkn_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] a_elem;
    logic signed [15:0] b_elem;
    logic               last_elem;

    modport source (output valid, a_elem, b_elem, last_elem, input ready);
    modport sink   (input valid, a_elem, b_elem, last_elem, output ready);
endinterface

FILE: rtl/pkn_out_if.sv
// Output channel: one kernel value per transfer.
// Depends on nothing.
interface pkn_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] kernel_value;
    logic               saturated;

    modport source (output valid, kernel_value, saturated, input ready);
    modport sink   (input valid, kernel_value, saturated, output ready);
endinterface

FILE: rtl/pkn_datapath.sv
// Datapath: accumulators, root, shift-add multiplier, divider and output format.
// Depends on pkn_pkg.
module pkn_datapath import pkn_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    input  t_cfg               i_cfg,
    input  logic signed [15:0] i_a_elem,
    input  logic signed [15:0] i_b_elem,
    output t_dp_stat           o_stat,
    output logic [31:0]        o_kernel_value,
    output logic               o_saturated
);

    logic [ACC_W-1:0]  r_cross, r_sa, r_sb;
    logic [XMAG_W-1:0] r_sb_hold, r_xsh;
    logic              r_norm, r_neg, r_special, r_force;
    logic [63:0]       r_s, r_res, r_bit;
    logic [5:0]        r_k, r_ka, r_kb;
    logic [30:0]       r_ma;
    logic [MUL_W-1:0]  r_mc, r_p, r_base;
    logic [2*MUL_W-1:0] r_mp;
    logic [61:0]       r_dvs, r_rem;
    logic [31:0]       r_q;
    logic [7:0]        r_total;
    logic [31:0]       r_kv;
    logic              r_sat;

    logic signed [31:0] w_ab, w_aa, w_bb;
    logic [ACC_W-1:0]  w_xn;
    logic [XMAG_W-1:0] w_x0, w_c, w_xm, w_sa, w_sb;
    logic              w_xneg, w_neg, w_special;
    logic [3:0]        w_deg;
    logic [63:0]       w_rb;
    logic [MUL_W:0]    w_madd;
    logic [62:0]       w_rem2;
    logic [31:0]       w_qc;
    logic [33:0]       w_mag;
    logic              w_over;

    // Element products for the three dot products.
    assign w_ab = i_a_elem * i_b_elem;
    assign w_aa = i_a_elem * i_a_elem;
    assign w_bb = i_b_elem * i_b_elem;

    // Shifted dot product magnitude and sign, and the shifted self sums.
    always_comb begin
        w_c    = i_cfg.add_one ? C_ONE : '0;
        w_xneg = r_cross[ACC_W-1];
        w_xn   = ~r_cross + ACC_W'(1);
        w_x0   = w_xneg ? {2'b00, w_xn} : {2'b00, r_cross};
        if (!w_xneg) begin
            w_xm = w_x0 + w_c;
        end else if (w_x0 > w_c) begin
            w_xm = w_x0 - w_c;
        end else begin
            w_xm   = w_c - w_x0;
            w_xneg = 1'b0;
        end
        w_deg     = (i_cfg.degree == 4'd0) ? 4'd1 : i_cfg.degree;
        w_neg     = w_xneg && w_deg[0] && (w_xm != '0);
        w_sa      = {2'b00, r_sa} + w_c;
        w_sb      = {2'b00, r_sb} + w_c;
        w_special = (w_sa == '0) || (w_sb == '0);
    end

    // One step of each iterative unit.
    assign w_rb   = r_res + r_bit;
    assign w_madd = {1'b0, r_mp[2*MUL_W-1:MUL_W]} + (r_mp[0] ? {1'b0, r_mc} : '0);
    assign w_rem2 = {r_rem, r_xsh[XMAG_W-1]};
    assign w_qc   = (r_q > 32'h4000_0000) ? 32'h4000_0000 : r_q;

    // Final magnitude and its saturation test.
    always_comb begin
        w_mag  = r_norm ? 34'(r_p >> (30 - OUT_FRAC_BITS)) : 34'(r_p >> (32 - OUT_FRAC_BITS));
        w_over = r_force || (!r_neg && (w_mag > 34'h0_7FFF_FFFF))
                 || (r_neg && (w_mag > 34'h0_8000_0000));
    end

    // Accumulators, cleared at reset and when a vector pair is finished.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cross <= '0;
            r_sa    <= '0;
            r_sb    <= '0;
        end else if (i_cmd.op == OP_ACC) begin
            r_cross <= r_cross + {{(ACC_W-32){w_ab[31]}}, w_ab};
            r_sa    <= r_sa + {{(ACC_W-32){1'b0}}, w_aa};
            r_sb    <= r_sb + {{(ACC_W-32){1'b0}}, w_bb};
        end else if (i_cmd.op == OP_PREP) begin
            r_cross <= '0;
            r_sa    <= '0;
            r_sb    <= '0;
        end
    end

    // Tail registers, driven one operation per cycle.
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_PREP: begin
                r_norm    <= i_cfg.normalize;
                r_neg     <= w_neg;
                r_special <= w_special;
                r_force   <= i_cfg.normalize ? (w_special && (w_xm != '0))
                                             : (w_xm >= (XMAG_W'(1) << UN_LIMIT));
                r_xsh     <= w_xm;
                r_s       <= {14'd0, w_sa};
                r_sb_hold <= w_sb;
                r_k       <= '0;
                r_p       <= i_cfg.normalize ? '0 : MUL_W'(w_xm << UN_SHIFT);
                r_base    <= MUL_W'(w_xm << UN_SHIFT);
            end
            OP_SCALE: begin
                r_s <= r_s << 2;
                r_k <= r_k + 6'd1;
            end
            OP_ROOT_INIT: begin
                r_res <= '0;
                r_bit <= 64'(1) << 62;
            end
            OP_ROOT_STEP: begin
                if (r_s >= w_rb) begin
                    r_s   <= r_s - w_rb;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            OP_LOAD_SB: begin
                r_ma <= r_res[30:0];
                r_ka <= r_k;
                r_s  <= {14'd0, r_sb_hold};
                r_k  <= '0;
            end
            OP_MUL_MM: begin
                r_kb <= r_k;
                r_mc <= {17'd0, r_ma};
                r_mp <= {{(MUL_W+17){1'b0}}, r_res[30:0]};
            end
            OP_MUL_STEP: begin
                r_mp <= {w_madd, r_mp[MUL_W-1:1]};
            end
            OP_DIV_INIT: begin
                r_dvs   <= r_mp[61:0];
                r_rem   <= '0;
                r_q     <= '0;
                r_total <= 8'd80 + {2'b00, r_ka} + {2'b00, r_kb};
            end
            OP_DIV_STEP: begin
                if (w_rem2 >= {1'b0, r_dvs}) begin
                    r_rem <= 62'(w_rem2 - {1'b0, r_dvs});
                    r_q   <= {r_q[30:0], 1'b1};
                end else begin
                    r_rem <= w_rem2[61:0];
                    r_q   <= {r_q[30:0], 1'b0};
                end
                r_xsh <= r_xsh << 1;
            end
            OP_CLAMP: begin
                r_p    <= MUL_W'(w_qc);
                r_base <= MUL_W'(w_qc);
            end
            OP_MUL_POW: begin
                r_mc <= r_base;
                r_mp <= {{MUL_W{1'b0}}, r_p};
            end
            OP_POW_UPD: begin
                if (r_norm) begin
                    r_p <= r_mp[77:30];
                end else if (r_mp[95:79] != '0) begin
                    r_force <= 1'b1;
                end else begin
                    r_p <= r_mp[79:32];
                end
            end
            OP_OUT: begin
                if (w_over) begin
                    r_kv  <= r_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
                    r_sat <= 1'b1;
                end else begin
                    r_kv  <= r_neg ? (~w_mag[31:0] + 32'd1) : w_mag[31:0];
                    r_sat <= 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_stat.special = r_special;
    assign o_stat.clip    = r_force;
    assign o_stat.s_small = (r_s[63:60] == 4'd0);
    assign o_stat.q_top   = r_q[31];
    assign o_stat.total   = r_total;
    assign o_kernel_value = r_kv;
    assign o_saturated    = r_sat;

endmodule

FILE: rtl/pkn_ctrl.sv
// Controller: sequences accumulation, root, multiply, divide and power steps.
// Depends on pkn_pkg.
module pkn_ctrl import pkn_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_last,
    output logic     o_in_ready,
    input  logic     i_out_ready,
    output logic     o_out_valid,
    input  t_cfg     i_cfg,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_PREP   = 4'd1;
    localparam logic [3:0] ST_DECIDE = 4'd2;
    localparam logic [3:0] ST_SCALE  = 4'd3;
    localparam logic [3:0] ST_ROOT   = 4'd4;
    localparam logic [3:0] ST_SAVE   = 4'd5;
    localparam logic [3:0] ST_MUL    = 4'd6;
    localparam logic [3:0] ST_MDONE  = 4'd7;
    localparam logic [3:0] ST_DIV    = 4'd8;
    localparam logic [3:0] ST_PCHK   = 4'd9;
    localparam logic [3:0] ST_OUT    = 4'd10;

    logic [3:0] r_state, n_state;
    logic [7:0] r_cnt, n_cnt;
    logic [3:0] r_j, n_j;
    logic       r_second, n_second;
    logic       r_mulpow, n_mulpow;
    logic       r_ovalid, n_ovalid;
    logic [3:0] w_deg;
    logic       w_out_free;

    assign w_deg      = (i_cfg.degree == 4'd0) ? 4'd1 : i_cfg.degree;
    assign w_out_free = !r_ovalid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE);
    assign o_out_valid = r_ovalid;

    // Next-state and command logic.
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_j      = r_j;
        n_second = r_second;
        n_mulpow = r_mulpow;
        n_ovalid = r_ovalid && !i_out_ready;
        o_cmd.op = OP_NONE;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_ACC;
                    if (i_last) n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                o_cmd.op = OP_PREP;
                n_state  = ST_DECIDE;
            end
            ST_DECIDE: begin
                n_second = 1'b0;
                n_j      = 4'd1;
                if (!i_cfg.normalize) n_state = ST_PCHK;
                else if (i_stat.special) n_state = ST_OUT;
                else n_state = ST_SCALE;
            end
            ST_SCALE: begin
                if (i_stat.s_small) begin
                    o_cmd.op = OP_SCALE;
                end else begin
                    o_cmd.op = OP_ROOT_INIT;
                    n_cnt    = '0;
                    n_state  = ST_ROOT;
                end
            end
            ST_ROOT: begin
                o_cmd.op = OP_ROOT_STEP;
                n_cnt    = r_cnt + 8'd1;
                if (r_cnt == 8'd31) n_state = ST_SAVE;
            end
            ST_SAVE: begin
                if (!r_second) begin
                    o_cmd.op = OP_LOAD_SB;
                    n_second = 1'b1;
                    n_state  = ST_SCALE;
                end else begin
                    o_cmd.op = OP_MUL_MM;
                    n_mulpow = 1'b0;
                    n_cnt    = '0;
                    n_state  = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.op = OP_MUL_STEP;
                n_cnt    = r_cnt + 8'd1;
                if (r_cnt == 8'(MUL_W - 1)) n_state = ST_MDONE;
            end
            ST_MDONE: begin
                if (r_mulpow) begin
                    o_cmd.op = OP_POW_UPD;
                    n_state  = ST_PCHK;
                end else begin
                    o_cmd.op = OP_DIV_INIT;
                    n_cnt    = '0;
                    n_state  = ST_DIV;
                end
            end
            ST_DIV: begin
                if (!i_stat.q_top && (r_cnt < i_stat.total)) begin
                    o_cmd.op = OP_DIV_STEP;
                    n_cnt    = r_cnt + 8'd1;
                end else begin
                    o_cmd.op = OP_CLAMP;
                    n_j      = 4'd1;
                    n_state  = ST_PCHK;
                end
            end
            ST_PCHK: begin
                if (i_stat.clip) begin
                    n_state = ST_OUT;
                end else if (r_j < w_deg) begin
                    o_cmd.op = OP_MUL_POW;
                    n_cnt    = '0;
                    n_mulpow = 1'b1;
                    n_j      = r_j + 4'd1;
                    n_state  = ST_MUL;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (w_out_free) begin
                    o_cmd.op = OP_OUT;
                    n_ovalid = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_j      <= '0;
            r_second <= 1'b0;
            r_mulpow <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_j      <= n_j;
            r_second <= n_second;
            r_mulpow <= n_mulpow;
            r_ovalid <= n_ovalid;
        end
    end

`ifndef SYNTHESIS
    a_root_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROOT) |-> (r_cnt < 8'd32))
        else $error("root step count out of range");
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && w_out_free) |=> (r_ovalid && r_state == ST_IDLE))
        else $error("result not loaded into output register");
    a_pow_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PCHK) |-> (r_j <= w_deg))
        else $error("power count exceeds degree");
    a_mul_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |-> (r_cnt < 8'(MUL_W)))
        else $error("multiplier step count out of range");
`endif

endmodule

FILE: rtl/polynomial_kernel_normalized.sv
// Top level of the normalized polynomial kernel: configuration registers,
// controller and datapath. Depends on pkn_pkg, pkn_in_if, pkn_out_if.
//
//   channel   direction  payload
//   in_ch     sink       a_elem, b_elem, last_elem
//   out_ch    source     kernel_value, saturated
//   i_cfg_*   write      degree, add_one, normalize
//
// Element pairs are taken one per cycle while the block is idle. After the last pair the tail
// runs alone: degree - 1 shift-add multiplies for the power when unnormalized, plus
// scaling, two 32-step roots, one multiply and a bit-serial divide when normalized.
// Reset is synchronous and clears the sums; a stalled result waits in the output register.
module polynomial_kernel_normalized import pkn_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pkn_in_if.sink     in_ch,
    pkn_out_if.source  out_ch,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [3:0] i_cfg_data
);

    t_cfg     r_cfg;
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic [31:0] w_kv;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.degree    <= 4'd2;
            r_cfg.add_one   <= 1'b1;
            r_cfg.normalize <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DEGREE:    r_cfg.degree    <= i_cfg_data;
                REG_ADD_ONE:   r_cfg.add_one   <= i_cfg_data[0];
                REG_NORMALIZE: r_cfg.normalize <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    pkn_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .i_last      (in_ch.last_elem),
        .o_in_ready  (in_ch.ready),
        .i_out_ready (out_ch.ready),
        .o_out_valid (out_ch.valid),
        .i_cfg       (r_cfg),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    pkn_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_cfg          (r_cfg),
        .i_a_elem       (in_ch.a_elem),
        .i_b_elem       (in_ch.b_elem),
        .o_stat         (w_stat),
        .o_kernel_value (w_kv),
        .o_saturated    (out_ch.saturated)
    );

    assign out_ch.kernel_value = w_kv;

endmodule
